// File: hdl/pcc_pkg.sv
// Package for the polar/Cartesian converter: CORDIC constants and the opcode type.
// No dependencies.
package pcc_pkg;

  typedef enum logic {
    OP_P2C = 1'b0,
    OP_C2P = 1'b1
  } pcc_op_e;

  localparam int ZW = 36;  // internal angle width, Q30 radians with headroom

  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [31:0]   GAIN_Q30    = 32'sd652032874;

  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    logic signed [ZW-1:0] t;
    unique case (i)
      0: t = 36'sd843314856;   1: t = 36'sd497837829;
      2: t = 36'sd263043836;   3: t = 36'sd133525158;
      4: t = 36'sd67021686;    5: t = 36'sd33543515;
      6: t = 36'sd16775850;    7: t = 36'sd8388437;
      8: t = 36'sd4194282;     9: t = 36'sd2097149;
      10: t = 36'sd1048575;    11: t = 36'sd524287;
      12: t = 36'sd262143;     13: t = 36'sd131071;
      14: t = 36'sd65535;      15: t = 36'sd32767;
      16: t = 36'sd16383;      17: t = 36'sd8191;
      18: t = 36'sd4095;       19: t = 36'sd2047;
      20: t = 36'sd1023;       21: t = 36'sd511;
      22: t = 36'sd255;        23: t = 36'sd127;
      24: t = 36'sd63;         25: t = 36'sd31;
      26: t = 36'sd15;         27: t = 36'sd7;
      28: t = 36'sd3;          29: t = 36'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// File: hdl/pcc_stage.sv
// One CORDIC micro-rotation stage of the converter pipeline, with its register.
// Depends on pcc_pkg.
module pcc_stage import pcc_pkg::*; #(
  parameter int unsigned DW   = 32,
  parameter int unsigned STEP = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic                 mode_i,   // 1: vectoring on y, 0: rotation on z
  input  logic                 side_i,
  input  logic signed [DW-1:0] px_i,
  input  logic signed [DW-1:0] py_i,
  input  logic signed [DW-1:0] vx_i,
  input  logic signed [DW-1:0] vy_i,
  input  logic signed [ZW-1:0] z_i,
  output logic                 valid_o,
  output logic                 mode_o,
  output logic                 side_o,
  output logic signed [DW-1:0] px_o,
  output logic signed [DW-1:0] py_o,
  output logic signed [DW-1:0] vx_o,
  output logic signed [DW-1:0] vy_o,
  output logic signed [ZW-1:0] z_o
);

  logic                 pos_d;
  logic signed [DW-1:0] px_d, py_d, vx_d, vy_d;
  logic signed [ZW-1:0] z_d;

  always_comb begin
    // positive rotation when rotating with z >= 0, or vectoring with y < 0
    pos_d = mode_i ? py_i[DW-1] : !z_i[ZW-1];
    if (pos_d) begin
      px_d = px_i - (py_i >>> STEP);
      py_d = py_i + (px_i >>> STEP);
      vx_d = vx_i - (vy_i >>> STEP);
      vy_d = vy_i + (vx_i >>> STEP);
      z_d  = z_i - atan_q30(STEP);
    end else begin
      px_d = px_i + (py_i >>> STEP);
      py_d = py_i - (px_i >>> STEP);
      vx_d = vx_i + (vy_i >>> STEP);
      vy_d = vy_i - (vx_i >>> STEP);
      z_d  = z_i + atan_q30(STEP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_o <= mode_i;
      side_o <= side_i;
      px_o   <= px_d;
      py_o   <= py_d;
      vx_o   <= vx_d;
      vy_o   <= vy_d;
      z_o    <= z_d;
    end
  end

endmodule

// File: hdl/pcc_gain.sv
// Gain correction: round-half-up of v * GAIN_Q30 / 2^30, then saturation or clamp, two stages.
// Depends on pcc_pkg.
module pcc_gain import pcc_pkg::*; #(
  parameter int unsigned DW = 32,
  parameter int unsigned OW = 24
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [DW-1:0] v_i,
  input  logic                 clamp_neg_i,
  output logic signed [OW-1:0] v_o
);

  localparam int unsigned PW = DW + 32;
  localparam logic signed [PW-1:0] RND = PW'(64'sd1 <<< 29);
  localparam logic signed [PW-1:0] OMAX = PW'((64'sd1 <<< (OW-1)) - 1);
  localparam logic signed [PW-1:0] OMIN = -OMAX - PW'(1);

  logic signed [PW-1:0] prod_q;
  logic                 clamp_q;
  logic signed [PW-1:0] res_d;
  logic signed [OW-1:0] sat_d;
  logic signed [OW-1:0] v_q;

  // product registered as the first stage, before rounding and clamping
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= PW'(v_i) * PW'(GAIN_Q30);
      clamp_q <= clamp_neg_i;
    end
  end

  always_comb begin
    res_d = (prod_q + RND) >>> 30;
    if (clamp_q && res_d[PW-1]) begin
      sat_d = '0;
    end else if (res_d > OMAX) begin
      sat_d = OMAX[OW-1:0];
    end else if (res_d < OMIN) begin
      sat_d = OMIN[OW-1:0];
    end else begin
      sat_d = res_d[OW-1:0];
    end
  end

  // rounded and clamped value registered as the second stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= sat_d;
    end
  end

  assign v_o = v_q;

endmodule

// File: hdl/polar_cartesian_converter.sv
// Pipelined CORDIC polar/Cartesian converter: takes one transfer per clock cycle while
// not stalled and raises out_valid_o for each result in input order;
// the item passes one input stage, one register stage per micro-rotation, a gain
// multiply, a rounding stage and the output register. A stall freezes the whole pipeline.
// Depends on pcc_pkg, pcc_stage and pcc_gain.
module polar_cartesian_converter import pcc_pkg::*; #(
  parameter int unsigned COORD_WIDTH    = 24,
  parameter int unsigned ANGLE_WIDTH    = 16,
  parameter int unsigned ROTATION_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic signed [COORD_WIDTH-1:0] pos_a_i,
  input  logic signed [ANGLE_WIDTH-1:0] pos_b_i,
  input  logic signed [COORD_WIDTH-1:0] pos_b_wide_i,
  input  logic signed [COORD_WIDTH-1:0] vec_a_i,
  input  logic signed [COORD_WIDTH-1:0] vec_b_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] out_pos_a_o,
  output logic signed [COORD_WIDTH-1:0] out_pos_b_o,
  output logic signed [COORD_WIDTH-1:0] out_vec_a_o,
  output logic signed [COORD_WIDTH-1:0] out_vec_b_o
);

  localparam int unsigned DW = COORD_WIDTH + 4;   // CORDIC growth headroom
  localparam int unsigned NS = ROTATION_STEPS;
  localparam int unsigned AS = 34 - ANGLE_WIDTH;
  localparam int unsigned CW = COORD_WIDTH;
  localparam logic signed [ZW-1:0] ARND = ZW'(64'sd1 <<< (AS-1));
  localparam logic signed [ZW-1:0] AMAX = ZW'((64'sd1 <<< (ANGLE_WIDTH-1)) - 1);
  localparam logic signed [ZW-1:0] AMIN = -AMAX - ZW'(1);

  logic en;

  // ---- input stage: angle reduction, pre-rotation, x == 0 bypass ----
  logic                 s0_valid_q, s0_mode_q, s0_byp_q;
  logic signed [DW-1:0] s0_px_q, s0_py_q, s0_vx_q, s0_vy_q;
  logic signed [ZW-1:0] s0_z_q;
  logic                 mode_d, byp_d;
  logic signed [DW-1:0] px_d, py_d, vx_d, vy_d;
  logic signed [ZW-1:0] z_d, zin_d;

  always_comb begin
    px_d   = DW'(pos_a_i);
    vx_d   = DW'(vec_a_i);
    vy_d   = DW'(vec_b_i);
    py_d   = '0;
    mode_d = (opcode_i == OP_C2P);
    byp_d  = 1'b0;
    zin_d  = ZW'(pos_b_i) <<< AS;
    z_d    = zin_d;
    if (!mode_d) begin
      // input angle spans -8 rad up to under +8 rad: at most two wraps each way
      if (zin_d >= PI_Q30 + TWO_PI_Q30) begin
        z_d = zin_d - TWO_PI_Q30 - TWO_PI_Q30;
      end else if (zin_d >= PI_Q30) begin
        z_d = zin_d - TWO_PI_Q30;
      end else if (zin_d < -PI_Q30 - TWO_PI_Q30) begin
        z_d = zin_d + TWO_PI_Q30 + TWO_PI_Q30;
      end else if (zin_d < -PI_Q30) begin
        z_d = zin_d + TWO_PI_Q30;
      end
      if (z_d > HALF_PI_Q30 || z_d < -HALF_PI_Q30) begin
        px_d = -px_d;
        vx_d = -vx_d;
        vy_d = -vy_d;
        z_d  = z_d[ZW-1] ? z_d + PI_Q30 : z_d - PI_Q30;
      end
    end else begin
      py_d = DW'(pos_b_wide_i);
      z_d  = '0;
      if (pos_a_i == '0) begin
        byp_d = 1'b1;
        // exact quarter turn; carry results in the x/v lanes
        if (!pos_b_wide_i[CW-1] && pos_b_wide_i != '0) begin
          px_d = py_d;
          vx_d = DW'(vec_b_i);
          vy_d = -DW'(vec_a_i);
          z_d  = HALF_PI_Q30;
        end else if (pos_b_wide_i[CW-1]) begin
          px_d = -py_d;
          vx_d = -DW'(vec_b_i);
          vy_d = DW'(vec_a_i);
          z_d  = -HALF_PI_Q30;
        end
      end else if (pos_a_i[CW-1]) begin
        px_d = -px_d;
        py_d = -py_d;
        vx_d = -vx_d;
        vy_d = -vy_d;
        z_d  = PI_Q30;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_mode_q <= mode_d;
      s0_byp_q  <= byp_d;
      s0_px_q   <= px_d;
      s0_py_q   <= py_d;
      s0_vx_q   <= vx_d;
      s0_vy_q   <= vy_d;
      s0_z_q    <= z_d;
    end
  end

  // ---- micro-rotation stages ----
  logic                 c_valid [NS+1];
  logic                 c_mode  [NS+1];
  logic                 c_byp   [NS+1];
  logic signed [DW-1:0] c_px    [NS+1];
  logic signed [DW-1:0] c_py    [NS+1];
  logic signed [DW-1:0] c_vx    [NS+1];
  logic signed [DW-1:0] c_vy    [NS+1];
  logic signed [ZW-1:0] c_z     [NS+1];

  assign c_valid[0] = s0_valid_q;
  assign c_mode[0]  = s0_mode_q;
  assign c_byp[0]   = s0_byp_q;
  assign c_px[0]    = s0_px_q;
  assign c_py[0]    = s0_py_q;
  assign c_vx[0]    = s0_vx_q;
  assign c_vy[0]    = s0_vy_q;
  assign c_z[0]     = s0_z_q;

  // bypassed items still pass the stages; their values are restored from a side copy
  logic signed [DW-1:0] bpx [NS+1];
  logic signed [DW-1:0] bvx [NS+1];
  logic signed [DW-1:0] bvy [NS+1];
  logic signed [ZW-1:0] bz  [NS+1];
  assign bpx[0] = s0_px_q;
  assign bvx[0] = s0_vx_q;
  assign bvy[0] = s0_vy_q;
  assign bz[0]  = s0_z_q;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    pcc_stage #(.DW(DW), .STEP(g)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (c_valid[g]),
      .mode_i  (c_mode[g]),
      .side_i  (c_byp[g]),
      .px_i    (c_px[g]),
      .py_i    (c_py[g]),
      .vx_i    (c_vx[g]),
      .vy_i    (c_vy[g]),
      .z_i     (c_z[g]),
      .valid_o (c_valid[g+1]),
      .mode_o  (c_mode[g+1]),
      .side_o  (c_byp[g+1]),
      .px_o    (c_px[g+1]),
      .py_o    (c_py[g+1]),
      .vx_o    (c_vx[g+1]),
      .vy_o    (c_vy[g+1]),
      .z_o     (c_z[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        bpx[g+1] <= bpx[g];
        bvx[g+1] <= bvx[g];
        bvy[g+1] <= bvy[g];
        bz[g+1]  <= bz[g];
      end
    end
  end

  // ---- gain stage: two registers deep ----
  logic signed [CW-1:0] g_px, g_py, g_vx, g_vy;
  logic                 e_valid_q [2];
  logic                 e_mode_q  [2];
  logic                 e_byp_q   [2];
  logic signed [CW-1:0] e_ang_q   [2];
  logic signed [CW-1:0] e_bpx_q   [2];
  logic signed [CW-1:0] e_bvx_q   [2];
  logic signed [CW-1:0] e_bvy_q   [2];
  logic signed [ZW-1:0] zr_d, zs_d, zsrc_d;
  logic signed [DW-1:0] bsat_px, bsat_vx, bsat_vy;

  pcc_gain #(.DW(DW), .OW(CW)) u_gain_px (
    .clk_i(clk_i), .en_i(en), .v_i(c_px[NS]), .clamp_neg_i(c_mode[NS]), .v_o(g_px)
  );
  pcc_gain #(.DW(DW), .OW(CW)) u_gain_py (
    .clk_i(clk_i), .en_i(en), .v_i(c_py[NS]), .clamp_neg_i(1'b0), .v_o(g_py)
  );
  pcc_gain #(.DW(DW), .OW(CW)) u_gain_vx (
    .clk_i(clk_i), .en_i(en), .v_i(c_vx[NS]), .clamp_neg_i(1'b0), .v_o(g_vx)
  );
  pcc_gain #(.DW(DW), .OW(CW)) u_gain_vy (
    .clk_i(clk_i), .en_i(en), .v_i(c_vy[NS]), .clamp_neg_i(1'b0), .v_o(g_vy)
  );

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] lo;
    hi = DW'((64'sd1 <<< (CW-1)) - 1);
    lo = -hi - DW'(1);
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  always_comb begin
    zsrc_d = c_byp[NS] ? bz[NS] : c_z[NS];
    zr_d   = (zsrc_d + ARND) >>> AS;
    if (zr_d > AMAX) begin
      zs_d = AMAX;
    end else if (zr_d < AMIN) begin
      zs_d = AMIN;
    end else begin
      zs_d = zr_d;
    end
    bsat_px = bpx[NS];
    bsat_vx = bvx[NS];
    bsat_vy = bvy[NS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q[0] <= 1'b0;
      e_valid_q[1] <= 1'b0;
    end else if (en) begin
      e_valid_q[0] <= c_valid[NS];
      e_valid_q[1] <= e_valid_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_mode_q[0] <= c_mode[NS];
      e_byp_q[0]  <= c_byp[NS];
      e_ang_q[0]  <= CW'(zs_d);
      e_bpx_q[0]  <= sat_cw(bsat_px);
      e_bvx_q[0]  <= sat_cw(bsat_vx);
      e_bvy_q[0]  <= sat_cw(bsat_vy);
      e_mode_q[1] <= e_mode_q[0];
      e_byp_q[1]  <= e_byp_q[0];
      e_ang_q[1]  <= e_ang_q[0];
      e_bpx_q[1]  <= e_bpx_q[0];
      e_bvx_q[1]  <= e_bvx_q[0];
      e_bvy_q[1]  <= e_bvy_q[0];
    end
  end

  // ---- output register ----
  logic                 out_valid_q;
  logic signed [CW-1:0] o_pa_q, o_pb_q, o_va_q, o_vb_q;

  // advance whenever the output slot is free or being drained
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= e_valid_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (e_byp_q[1]) begin
        o_pa_q <= e_bpx_q[1];
        o_pb_q <= e_ang_q[1];
        o_va_q <= e_bvx_q[1];
        o_vb_q <= e_bvy_q[1];
      end else begin
        o_pa_q <= g_px;
        o_pb_q <= e_mode_q[1] ? e_ang_q[1] : g_py;
        o_va_q <= g_vx;
        o_vb_q <= g_vy;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pos_a_o = o_pa_q;
  assign out_pos_b_o = o_pb_q;
  assign out_vec_a_o = o_va_q;
  assign out_vec_b_o = o_vb_q;

endmodule
